// ===== hdl/idiv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the integer divider.
// Used by every module of the divider and by its checker.
package idiv_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned HalfW  = 16;
	localparam int unsigned Steps  = DataW;
	localparam int unsigned Latency = Steps + 2;

	typedef enum logic [1:0] {
		ACT_S16 = 2'd0,
		ACT_U16 = 2'd1,
		ACT_U32 = 2'd2
	} action_t;

	typedef struct packed {
		logic narrow;
		logic neg_q;
		logic neg_r;
		logic zero;
	} ctl_t;

endpackage
`default_nettype wire

// ===== hdl/idiv_pre.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Operand conditioning: mode decode, magnitudes and sign flags.
// Depends on idiv_pkg.
module idiv_pre import idiv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [1:0]       action,
	input  wire logic [DataW-1:0] dividend,
	input  wire logic [DataW-1:0] divisor,
	output logic                  valid_s1,
	output ctl_t                  ctl_s1,
	output logic [DataW-1:0]      num_s1,
	output logic [DataW-1:0]      den_s1
);

	ctl_t             ctl_d;
	logic [DataW-1:0] num_d;
	logic [DataW-1:0] den_d;
	logic [HalfW-1:0] a16;
	logic [HalfW-1:0] b16;
	logic [HalfW-1:0] a16_abs;
	logic [HalfW-1:0] b16_abs;

	assign a16     = dividend[HalfW-1:0];
	assign b16     = divisor[HalfW-1:0];
	assign a16_abs = a16[HalfW-1] ? (HalfW'(0) - a16) : a16;
	assign b16_abs = b16[HalfW-1] ? (HalfW'(0) - b16) : b16;

	always_comb begin
		unique case (action_t'(action))
			ACT_S16: begin
				ctl_d.narrow = 1'b1;
				ctl_d.zero   = (b16 == '0);
				ctl_d.neg_r  = a16[HalfW-1];
				ctl_d.neg_q  = (a16[HalfW-1] ^ b16[HalfW-1]) & (b16 != '0);
				num_d        = {{(DataW-HalfW){1'b0}}, a16_abs};
				den_d        = {{(DataW-HalfW){1'b0}}, b16_abs};
			end
			ACT_U16: begin
				ctl_d.narrow = 1'b1;
				ctl_d.zero   = (b16 == '0);
				ctl_d.neg_r  = 1'b0;
				ctl_d.neg_q  = 1'b0;
				num_d        = {{(DataW-HalfW){1'b0}}, a16};
				den_d        = {{(DataW-HalfW){1'b0}}, b16};
			end
			default: begin
				ctl_d.narrow = 1'b0;
				ctl_d.zero   = (divisor == '0);
				ctl_d.neg_r  = 1'b0;
				ctl_d.neg_q  = 1'b0;
				num_d        = dividend;
				den_d        = divisor;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl_d;
		num_s1 <= num_d;
		den_s1 <= den_d;
	end

endmodule
`default_nettype wire

// ===== hdl/idiv_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One restoring division step: one quotient bit per pipeline stage.
// Depends on idiv_pkg.
module idiv_step import idiv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_i,
	input  wire ctl_t             ctl_i,
	input  wire logic [DataW-1:0] rem_i,
	input  wire logic [DataW-1:0] num_i,
	input  wire logic [DataW-1:0] den_i,
	output logic                  valid_sn,
	output ctl_t                  ctl_sn,
	output logic [DataW-1:0]      rem_sn,
	output logic [DataW-1:0]      num_sn,
	output logic [DataW-1:0]      den_sn
);

	logic [DataW+1:0] diff;
	logic             fits;

	assign diff = {1'b0, rem_i, num_i[DataW-1]} - {2'b00, den_i};
	assign fits = !diff[DataW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else begin
			valid_sn <= valid_i;
		end
	end

	// shift the next dividend bit into the remainder, the quotient bit into num
	always_ff @(posedge clk) begin
		ctl_sn <= ctl_i;
		den_sn <= den_i;
		rem_sn <= fits ? diff[DataW-1:0] : {rem_i[DataW-2:0], num_i[DataW-1]};
		num_sn <= {num_i[DataW-2:0], fits};
	end

endmodule
`default_nettype wire

// ===== hdl/idiv_post.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result fixup: sign restore and masking to the mode width.
// Depends on idiv_pkg.
module idiv_post import idiv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_i,
	input  wire ctl_t             ctl_i,
	input  wire logic [DataW-1:0] rem_i,
	input  wire logic [DataW-1:0] quo_i,
	output logic                  done_s34,
	output logic [DataW-1:0]      quotient_s34,
	output logic [DataW-1:0]      remainder_s34,
	output logic                  zero_s34
);

	logic [DataW-1:0] quo_fix;
	logic [DataW-1:0] rem_fix;
	logic [DataW-1:0] mask;

	assign mask    = ctl_i.narrow ? {{(DataW-HalfW){1'b0}}, {HalfW{1'b1}}} : '1;
	assign quo_fix = ctl_i.neg_q ? (DataW'(0) - quo_i) : quo_i;
	assign rem_fix = ctl_i.neg_r ? (DataW'(0) - rem_i) : rem_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s34 <= 1'b0;
		end else begin
			done_s34 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		quotient_s34  <= quo_fix & mask;
		remainder_s34 <= rem_fix & mask;
		zero_s34      <= ctl_i.zero;
	end

endmodule
`default_nettype wire

// ===== hdl/integer_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Integer divider, signed 16-bit, unsigned 16-bit and unsigned 32-bit modes.
// A word passes from the start edge to the done word through one conditioning
// stage, 32 one-bit restoring stages and one fixup stage. Throughput: one word
// per cycle; busy is always low and results are never held off.
// Reset: arst_n clears all valid bits at once; payload registers are not reset.
module integer_divider import idiv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [1:0]       action,
	input  wire logic [DataW-1:0] dividend,
	input  wire logic [DataW-1:0] divisor,
	output logic                  done,
	output logic [DataW-1:0]      quotient,
	output logic [DataW-1:0]      remainder,
	output logic                  div_by_zero
);

	logic             valid_p [Steps+1];
	ctl_t             ctl_p   [Steps+1];
	logic [DataW-1:0] rem_p   [Steps+1];
	logic [DataW-1:0] num_p   [Steps+1];
	logic [DataW-1:0] den_p   [Steps+1];

	assign busy     = 1'b0;
	assign rem_p[0] = '0;

	idiv_pre u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.action   (action),
		.dividend (dividend),
		.divisor  (divisor),
		.valid_s1 (valid_p[0]),
		.ctl_s1   (ctl_p[0]),
		.num_s1   (num_p[0]),
		.den_s1   (den_p[0])
	);

	for (genvar i = 0; i < Steps; i++) begin : g_step
		idiv_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_i  (valid_p[i]),
			.ctl_i    (ctl_p[i]),
			.rem_i    (rem_p[i]),
			.num_i    (num_p[i]),
			.den_i    (den_p[i]),
			.valid_sn (valid_p[i+1]),
			.ctl_sn   (ctl_p[i+1]),
			.rem_sn   (rem_p[i+1]),
			.num_sn   (num_p[i+1]),
			.den_sn   (den_p[i+1])
		);
	end

	idiv_post u_post (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_i       (valid_p[Steps]),
		.ctl_i         (ctl_p[Steps]),
		.rem_i         (rem_p[Steps]),
		.quo_i         (num_p[Steps]),
		.done_s34      (done),
		.quotient_s34  (quotient),
		.remainder_s34 (remainder),
		.zero_s34      (div_by_zero)
	);

endmodule
`default_nettype wire

// ===== hdl/idiv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the integer divider, bound to the top level.
// Depends on idiv_pkg and integer_divider.
module idiv_checker import idiv_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done,
	input wire logic [DataW-1:0] quotient,
	input wire logic [DataW-1:0] remainder,
	input wire logic             div_by_zero
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("divider reported busy");

	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(Latency) done)
		else $error("word did not complete after pipeline latency");

	a_zero_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_by_zero) |-> (quotient[HalfW-1:0] == {HalfW{1'b1}}))
		else $error("divide by zero quotient not all ones");

	a_narrow_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_by_zero && (quotient[DataW-1:HalfW] == '0))
		|-> (remainder[DataW-1:HalfW] == '0))
		else $error("narrow remainder has upper bits set");

endmodule

bind integer_divider idiv_checker u_idiv_checker (.*);
`default_nettype wire

// ===== bench/integer_divider_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for integer_divider: queued operand words, random start gaps,
// and a predictor of truncating quotient, remainder and divide-by-zero flag per word.
// Depends on idiv_pkg for widths, latency and the action codes.
module integer_divider_tb;
	import idiv_pkg::*;

	localparam logic [1:0]       ACT_SPARE  = 2'd3;
	localparam logic [DataW-1:0] Mask16     = 32'h0000_FFFF;
	localparam logic [DataW-1:0] Mask32     = 32'hFFFF_FFFF;
	localparam int               RandWords  = 1400;
	localparam int               CalmTail   = 150;
	localparam int               CycleLimit = 200000;

	typedef struct {
		logic [1:0]       action;
		logic [DataW-1:0] dividend;
		logic [DataW-1:0] divisor;
		bit               drain_first;
	} div_word_t;

	typedef struct {
		logic [DataW-1:0] quotient;
		logic [DataW-1:0] remainder;
		logic             div_by_zero;
	} div_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [1:0]       action = 2'd0;
	logic [DataW-1:0] dividend = '0;
	logic [DataW-1:0] divisor = '0;
	logic             busy;
	logic             done;
	logic [DataW-1:0] quotient;
	logic [DataW-1:0] remainder;
	logic             div_by_zero;

	div_word_t   pending_words[$];
	div_result_t predicted_results[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          idle_left = 0;
	int          calm_left = 0;

	integer_divider u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.dividend   (dividend),
		.divisor    (divisor),
		.done       (done),
		.quotient   (quotient),
		.remainder  (remainder),
		.div_by_zero(div_by_zero)
	);

	always #5 clk = ~clk;

	function automatic div_result_t divide_word(input div_word_t w);
		div_result_t      res;
		logic signed [31:0] sa, sb, sq, sr;
		logic [DataW-1:0] ua, ub;
		res.div_by_zero = 1'b0;
		if (w.action == ACT_S16) begin
			if (w.divisor[HalfW-1:0] == '0) begin
				res.quotient    = Mask16;
				res.remainder   = w.dividend & Mask16;
				res.div_by_zero = 1'b1;
			end else begin
				sa = 32'($signed(w.dividend[HalfW-1:0]));
				sb = 32'($signed(w.divisor[HalfW-1:0]));
				sq = sa / sb;
				sr = sa % sb;
				res.quotient  = sq & Mask16;
				res.remainder = sr & Mask16;
			end
		end else if (w.action == ACT_U16) begin
			ua = w.dividend & Mask16;
			ub = w.divisor & Mask16;
			if (ub == '0) begin
				res.quotient    = Mask16;
				res.remainder   = ua;
				res.div_by_zero = 1'b1;
			end else begin
				res.quotient  = ua / ub;
				res.remainder = ua % ub;
			end
		end else begin
			if (w.divisor == '0) begin
				res.quotient    = Mask32;
				res.remainder   = w.dividend;
				res.div_by_zero = 1'b1;
			end else begin
				res.quotient  = w.dividend / w.divisor;
				res.remainder = w.dividend % w.divisor;
			end
		end
		return res;
	endfunction

	task automatic add_word(input logic [1:0] act, input logic [DataW-1:0] a,
			input logic [DataW-1:0] b, input bit drain);
		div_word_t w;
		w.action      = act;
		w.dividend    = a;
		w.divisor     = b;
		w.drain_first = drain;
		pending_words.push_back(w);
	endtask

	function automatic logic [DataW-1:0] pick_operand();
		logic [DataW-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4, 5: v = {v[31:16], 12'h000, v[3:0]};
			6: v = v & 32'h0000_00FF;
			7: v = {v[31:16], 16'h0000};
			8: begin
				case ($urandom_range(0, 6))
					0: v = '0;
					1: v = 32'd1;
					2: v = Mask16;
					3: v = 32'h0000_8000;
					4: v = 32'h0000_7FFF;
					5: v = Mask32;
					default: v = 32'h8000_0000;
				endcase
			end
			default: v = v >> $urandom_range(1, 31);
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// driver: hold a presented word until taken, otherwise idle in bursts or present the next
	always @(posedge clk) begin
		bit launch;
		if (arst_n) begin
			if (start && !busy) begin
				predicted_results.push_back(divide_word(pending_words[0]));
				pending_words.delete(0);
				if (calm_left > 0)
					calm_left--;
			end
			if (!(start && busy)) begin
				launch = 1'b0;
				if (idle_left > 0)
					idle_left--;
				if (pending_words.size() != 0 && idle_left == 0) begin
					launch = 1'b1;
					if (pending_words[0].drain_first && predicted_results.size() != 0)
						launch = 1'b0;
					else if (pending_words.size() > CalmTail && calm_left == 0) begin
						if ($urandom_range(0, 29) == 0)
							calm_left = $urandom_range(20, 60);
						else if ($urandom_range(0, 4) == 0) begin
							idle_left = $urandom_range(1, 14);
							launch = 1'b0;
						end
					end
				end
				start <= launch;
				if (launch) begin
					action   <= pending_words[0].action;
					dividend <= pending_words[0].dividend;
					divisor  <= pending_words[0].divisor;
				end
			end
		end
	end

	// monitor: compare each done word against the oldest prediction
	always @(posedge clk) begin
		div_result_t exp_res;
		if (arst_n && done) begin
			if (predicted_results.size() == 0)
				report_mismatch("done word with no prediction pending");
			else begin
				exp_res = predicted_results.pop_front();
				if (quotient !== exp_res.quotient)
					report_mismatch($sformatf("quotient %h, predicted %h",
						quotient, exp_res.quotient));
				if (remainder !== exp_res.remainder)
					report_mismatch($sformatf("remainder %h, predicted %h",
						remainder, exp_res.remainder));
				if (div_by_zero !== exp_res.div_by_zero)
					report_mismatch($sformatf("div_by_zero %b, predicted %b",
						div_by_zero, exp_res.div_by_zero));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("integer_divider regression: fail");
			$finish;
		end
	end

	initial begin
		logic [1:0]       act;
		logic [DataW-1:0] a, b;
		// directed corners
		add_word(ACT_S16, 32'hABCD_8000, 32'h1234_FFFF, 1'b0);
		add_word(ACT_S16, 32'd7, 32'h0000_FFFE, 1'b0);
		add_word(ACT_S16, 32'h0000_FFF9, 32'd2, 1'b0);
		add_word(ACT_S16, 32'h0000_FFF9, 32'h0000_FFFE, 1'b0);
		add_word(ACT_S16, 32'h0000_7FFF, 32'd1, 1'b0);
		add_word(ACT_S16, 32'h0000_8000, 32'd1, 1'b0);
		add_word(ACT_S16, 32'h0000_8000, 32'h0000_7FFF, 1'b0);
		add_word(ACT_S16, 32'd5, 32'd0, 1'b0);
		add_word(ACT_S16, 32'hFFFF_8000, 32'hFFFF_0000, 1'b0);
		add_word(ACT_U16, 32'h0000_FFFF, 32'd1, 1'b0);
		add_word(ACT_U16, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b0);
		add_word(ACT_U16, 32'd1, 32'h0000_FFFF, 1'b0);
		add_word(ACT_U16, 32'd1234, 32'h0001_0000, 1'b0);
		add_word(ACT_U16, 32'd0, 32'd0, 1'b0);
		add_word(ACT_U16, 32'h5555_1234, 32'hAAAA_0007, 1'b0);
		add_word(ACT_U32, Mask32, 32'd1, 1'b0);
		add_word(ACT_U32, Mask32, Mask32, 1'b0);
		add_word(ACT_U32, 32'd0, Mask32, 1'b0);
		add_word(ACT_U32, 32'h8000_0000, 32'd0, 1'b0);
		add_word(ACT_U32, 32'hDEAD_BEEF, 32'h0001_0000, 1'b0);
		add_word(ACT_U32, 32'h0000_0003, 32'h8000_0000, 1'b0);
		add_word(ACT_SPARE, 32'd100, 32'd7, 1'b0);
		add_word(ACT_SPARE, 32'hFFFF_0005, 32'd0, 1'b0);
		for (int i = 0; i < RandWords; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: act = ACT_S16;
				6, 7, 8, 9, 10, 11: act = ACT_U16;
				19: act = ACT_SPARE;
				default: act = ACT_U32;
			endcase
			a = pick_operand();
			b = pick_operand();
			if ($urandom_range(0, 49) == 0) begin
				act = ACT_S16;
				a = {16'($urandom_range(0, 16'hFFFF)), 16'h8000};
				b = {16'($urandom_range(0, 16'hFFFF)), 16'hFFFF};
			end
			add_word(act, a, b,
				i == 0 || (i < RandWords - CalmTail && $urandom_range(0, 249) == 0));
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_words.size() != 0 || predicted_results.size() != 0)
			@(posedge clk);
		repeat (Latency + 16) @(posedge clk);
		if (mismatch_count == 0)
			$display("integer_divider regression: pass");
		else
			$display("integer_divider regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/idiv_pkg.sv
hdl/idiv_pre.sv
hdl/idiv_step.sv
hdl/idiv_post.sv
hdl/integer_divider.sv
hdl/idiv_checker.sv
bench/integer_divider_tb.sv
